/* rtl/pds_pkg.sv */
// shared types and constants for the pll divider search
package pds_pkg;

  localparam int KHZ_W     = 20;
  localparam int RATIO_W   = 31;
  localparam int VCO_W     = 32;
  localparam int ERR_W     = 35;
  localparam int FRAC_BITS = 24;

  localparam logic [6:0]  REF_NUM  = 7'd100;
  localparam logic [20:0] REF_DEN  = 21'd1431818;
  localparam logic [23:0] REF_HALF = 24'd715909;

  localparam logic [2:0] REG_MIN_MULT   = 3'd0;
  localparam logic [2:0] REG_MIN_PREDIV = 3'd1;
  localparam logic [2:0] REG_MAX_PREDIV = 3'd2;
  localparam logic [2:0] REG_MIN_POSTDV = 3'd3;
  localparam logic [2:0] REG_MAX_POSTDV = 3'd4;
  localparam logic [2:0] REG_VCO_MIN    = 3'd5;
  localparam logic [2:0] REG_VCO_MAX    = 3'd6;

  localparam logic [7:0]       RST_MIN_MULT   = 8'd1;
  localparam logic [5:0]       RST_MIN_PREDIV = 6'd1;
  localparam logic [5:0]       RST_MAX_PREDIV = 6'd63;
  localparam logic [1:0]       RST_MIN_POSTDV = 2'd0;
  localparam logic [1:0]       RST_MAX_POSTDV = 2'd3;
  localparam logic [KHZ_W-1:0] RST_VCO_MIN    = 20'd20000;
  localparam logic [KHZ_W-1:0] RST_VCO_MAX    = 20'd200000;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  localparam logic [1:0] DIV_TARGET = 2'd0;
  localparam logic [1:0] DIV_VMIN   = 2'd1;
  localparam logic [1:0] DIV_VMAX   = 2'd2;

  localparam logic [7:0] DEF_M  = 8'd255;
  localparam logic [5:0] DEF_N1 = 6'd63;
  localparam logic [1:0] DEF_N2 = 2'd3;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       clamp;
    logic       issue;
    logic       out_load;
  } pds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic search_empty;
    logic issue_last;
    logic pipe_busy;
  } pds_stat_t;

endpackage

/* rtl/pds_kdiv.sv */
// pipelined reciprocal divider turning a khz value into a q7.24 ratio to the reference
module pds_kdiv import pds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [KHZ_W-1:0]   khz,
  output logic               done,
  output logic [RATIO_W-1:0] quo
);

  localparam int NUM_W  = KHZ_W + $bits(REF_NUM);
  localparam int REM_W  = $bits(REF_DEN);
  localparam int QA_W   = RATIO_W - FRAC_BITS;
  localparam int PA_W   = NUM_W + QA_W;
  localparam int RB_W   = FRAC_BITS + 1;
  localparam int RB_K   = REM_W + FRAC_BITS;
  localparam int PB_W   = REM_W + RB_W;
  localparam int SB_W   = PB_W + FRAC_BITS;
  localparam int Y_W    = REM_W + FRAC_BITS;
  localparam int STAGES = 7;

  // reciprocals of the reference divisor, rounded down
  localparam logic [QA_W-1:0] RCP_A    = QA_W'((64'd1 << NUM_W) / 64'(REF_DEN));
  localparam logic [RB_W-1:0] RCP_B    = RB_W'((64'd1 << RB_K) / 64'(REF_DEN));
  localparam logic [SB_W-1:0] HALF_RCP = SB_W'(64'(REF_HALF) * 64'(RCP_B));

  logic [STAGES-1:0]    vld;
  logic [NUM_W-1:0]     num0;
  logic [NUM_W-1:0]     num1;
  logic [PA_W-1:0]      pa;
  logic [QA_W-1:0]      qa1;
  logic [QA_W-1:0]      qa2;
  logic [QA_W-1:0]      qa3;
  logic [QA_W-1:0]      qa4;
  logic [QA_W-1:0]      qa5;
  logic [QA_W-1:0]      qa6;
  logic [NUM_W-1:0]     ra_full;
  logic [REM_W:0]       ra2;
  logic [REM_W:0]       ra_diff;
  logic                 ra_ge;
  logic [REM_W-1:0]     ra3;
  logic [REM_W-1:0]     ra4;
  logic [REM_W-1:0]     ra5;
  logic [PB_W-1:0]      pb4;
  logic [SB_W-1:0]      sb;
  logic [FRAC_BITS-1:0] qb5;
  logic [FRAC_BITS-1:0] qb6;
  logic [Y_W-1:0]       rb_full;
  logic [REM_W:0]       rb6;
  logic                 rb_ge;

  // integer part: khz * 100 / den, estimate then one correction
  assign pa      = PA_W'(num0) * PA_W'(RCP_A);
  assign ra_full = num1 - NUM_W'(qa1) * NUM_W'(REF_DEN);
  assign ra_ge   = ra2 >= {1'b0, REF_DEN};
  assign ra_diff = ra2 - {1'b0, REF_DEN};

  // fraction: (rem * 2^24 + half) / den, estimate then one correction
  assign sb      = {pb4, FRAC_BITS'(0)} + HALF_RCP;
  assign rb_full = {ra5, REF_HALF} - Y_W'(qb5) * Y_W'(REF_DEN);
  assign rb_ge   = rb6 >= {1'b0, REF_DEN};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[STAGES-2:0], start};
      done <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    num0 <= NUM_W'(khz) * NUM_W'(REF_NUM);

    qa1  <= pa[PA_W-1:NUM_W];
    num1 <= num0;

    ra2 <= ra_full[REM_W:0];
    qa2 <= qa1;

    ra3 <= ra_ge ? ra_diff[REM_W-1:0] : ra2[REM_W-1:0];
    qa3 <= qa2 + QA_W'(ra_ge);

    pb4 <= PB_W'(ra3) * PB_W'(RCP_B);
    ra4 <= ra3;
    qa4 <= qa3;

    qb5 <= sb[RB_K+FRAC_BITS-1:RB_K];
    ra5 <= ra4;
    qa5 <= qa4;

    rb6 <= rb_full[REM_W:0];
    qb6 <= qb5;
    qa6 <= qa5;

    if (vld[STAGES-1]) begin
      quo <= {qa6, qb6 + FRAC_BITS'(rb_ge)};
    end
  end

endmodule

/* rtl/pds_datapath.sv */
// config registers, ratio divider, candidate pipeline and best-pair tracking
module pds_datapath import pds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [KHZ_W-1:0] cfg_data,
  input  logic [KHZ_W-1:0] target_khz,
  input  pds_cmd_t         cmd,
  output pds_stat_t        stat,
  output logic [7:0]       multiplier,
  output logic [7:0]       divider_byte,
  output logic [1:0]       clamp_code
);

  localparam int RCP_W = 33;
  localparam int RCP_K = 32;
  localparam int P_W   = RATIO_W + 6;
  localparam int SH_W  = P_W + 4;
  localparam int MF_W  = SH_W - FRAC_BITS;
  localparam int A_W   = 8 + RCP_W;
  localparam int B_W   = 5 + RCP_W;
  localparam int S_W   = A_W + FRAC_BITS;

  // config registers
  logic [7:0]       min_multiplier;
  logic [5:0]       min_prediv;
  logic [5:0]       max_prediv;
  logic [1:0]       min_postdiv_exp;
  logic [1:0]       max_postdiv_exp;
  logic [KHZ_W-1:0] vco_min_khz;
  logic [KHZ_W-1:0] vco_max_khz;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_multiplier  <= RST_MIN_MULT;
      min_prediv      <= RST_MIN_PREDIV;
      max_prediv      <= RST_MAX_PREDIV;
      min_postdiv_exp <= RST_MIN_POSTDV;
      max_postdiv_exp <= RST_MAX_POSTDV;
      vco_min_khz     <= RST_VCO_MIN;
      vco_max_khz     <= RST_VCO_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_MULT:   min_multiplier  <= cfg_data[7:0];
        REG_MIN_PREDIV: min_prediv      <= cfg_data[5:0];
        REG_MAX_PREDIV: max_prediv      <= cfg_data[5:0];
        REG_MIN_POSTDV: min_postdiv_exp <= cfg_data[1:0];
        REG_MAX_POSTDV: max_postdiv_exp <= cfg_data[1:0];
        REG_VCO_MIN:    vco_min_khz     <= cfg_data;
        REG_VCO_MAX:    vco_max_khz     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ratio conversion
  logic [KHZ_W-1:0]   tgt_khz;
  logic [KHZ_W-1:0]   div_khz;
  logic               div_done;
  logic [RATIO_W-1:0] div_quo;
  logic [RATIO_W-1:0] target;
  logic [RATIO_W-1:0] vmin;
  logic [RATIO_W-1:0] vmax;

  always_comb begin
    case (cmd.div_sel)
      DIV_TARGET: div_khz = tgt_khz;
      DIV_VMIN:   div_khz = vco_min_khz;
      DIV_VMAX:   div_khz = vco_max_khz;
      default:    div_khz = tgt_khz;
    endcase
  end

  pds_kdiv u_kdiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .khz   (div_khz),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamp
  logic [RATIO_W-1:0] lo;
  logic [RATIO_W-1:0] hi;
  logic [RATIO_W-1:0] t_lo;
  logic [RATIO_W-1:0] t_cl;
  logic [1:0]         code_cl;

  assign lo = vmin >> max_postdiv_exp;
  assign hi = vmax >> min_postdiv_exp;

  always_comb begin
    t_lo    = target;
    code_cl = CLAMP_NONE;
    if (target < lo) begin
      t_lo    = lo;
      code_cl = CLAMP_LOW;
    end
    t_cl = t_lo;
    if (t_lo > hi) begin
      t_cl    = hi;
      code_cl = CLAMP_HIGH;
    end
  end

  logic [1:0] clamp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_khz <= target_khz;
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_TARGET: target <= div_quo;
        DIV_VMIN:   vmin   <= div_quo;
        DIV_VMAX:   vmax   <= div_quo;
        default: ;
      endcase
    end else if (cmd.clamp) begin
      target <= t_cl;
    end
    if (cmd.clamp) begin
      clamp_r <= code_cl;
    end
  end

  // candidate counters
  logic [5:0] n1c;
  logic [1:0] n2c;

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      n1c <= min_prediv;
      n2c <= min_postdiv_exp;
    end else if (cmd.issue) begin
      if (n1c == max_prediv) begin
        n1c <= min_prediv;
        n2c <= n2c + 2'd1;
      end else begin
        n1c <= n1c + 6'd1;
      end
    end
  end

  assign stat.div_done     = div_done;
  assign stat.search_empty = (min_prediv > max_prediv) || (min_postdiv_exp > max_postdiv_exp);
  assign stat.issue_last   = (n1c == max_prediv) && (n2c == max_postdiv_exp);

  // reciprocal table floor(2^32 / n1)
  logic [RCP_W-1:0] rcp_tab [64];

  assign rcp_tab[0] = '0;
  for (genvar gi = 1; gi < 64; gi++) begin : g_rcp
    localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RCP_K) / gi);
    assign rcp_tab[gi] = RCP;
  end

  // stage 1: target * n1
  logic           v1;
  logic [P_W-1:0] p1;
  logic [5:0]     n1_1;
  logic [1:0]     n2_1;

  // stage 2: rounded multiplier
  logic            v2;
  logic [7:0]      m2;
  logic [5:0]      n1_2;
  logic [1:0]      n2_2;
  logic [SH_W-1:0] sh2;
  logic [MF_W-1:0] mfull;
  logic            m_ok;

  assign sh2   = (SH_W'(p1) << n2_1) + SH_W'(1 << (FRAC_BITS - 1));
  assign mfull = sh2[SH_W-1:FRAC_BITS];
  assign m_ok  = (mfull <= MF_W'(255)) && (mfull[7:0] >= min_multiplier);

  // stage 3: reciprocal products
  logic           v3;
  logic [A_W-1:0] a3;
  logic [B_W-1:0] b3;
  logic [7:0]     m3;
  logic [5:0]     n1_3;
  logic [1:0]     n2_3;
  logic [RCP_W-1:0] rcp;

  assign rcp = rcp_tab[n1_2];

  // stage 4: quotient estimate
  logic             v4;
  logic [VCO_W-1:0] q4;
  logic [7:0]       m4;
  logic [5:0]       n1_4;
  logic [1:0]       n2_4;
  logic [S_W-1:0]   sum3;

  assign sum3 = {a3, FRAC_BITS'(0)} + S_W'(b3);

  // stage 5: correction
  logic             v5;
  logic [VCO_W-1:0] vco5;
  logic [1:0]       n2_5;
  logic [7:0]       m5;
  logic [5:0]       n1_5;
  logic [VCO_W+5:0] qn4;
  logic [VCO_W-1:0] x4;
  logic [VCO_W-1:0] r4;

  assign qn4 = (VCO_W+6)'(q4) * (VCO_W+6)'(n1_4);
  assign x4  = {m4, 19'd0, n1_4[5:1]};
  assign r4  = x4 - qn4[VCO_W-1:0];

  // stage 6: window check and error
  logic             v6;
  logic [ERR_W-1:0] err6;
  logic [7:0]       m6;
  logic [5:0]       n1_6;
  logic [1:0]       n2_6;
  logic             win_ok;
  logic [ERR_W-1:0] scaled5;
  logic [ERR_W-1:0] t8;

  assign win_ok  = (vco5 >= VCO_W'(vmin)) && (vco5 <= VCO_W'(vmax));
  assign scaled5 = {vco5, 3'd0} >> n2_5;
  assign t8      = ERR_W'({target, 3'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= cmd.issue && (n1c != 6'd0);
      v2 <= v1 && m_ok;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5 && win_ok;
    end
  end

  always_ff @(posedge clk) begin
    p1   <= P_W'(target) * P_W'(n1c);
    n1_1 <= n1c;
    n2_1 <= n2c;

    m2   <= mfull[7:0];
    n1_2 <= n1_1;
    n2_2 <= n2_1;

    a3   <= A_W'(m2) * A_W'(rcp);
    b3   <= B_W'(n1_2[5:1]) * B_W'(rcp);
    m3   <= m2;
    n1_3 <= n1_2;
    n2_3 <= n2_2;

    q4   <= sum3[2*RCP_K-1:RCP_K];
    m4   <= m3;
    n1_4 <= n1_3;
    n2_4 <= n2_3;

    vco5 <= q4 + VCO_W'(r4 >= VCO_W'(n1_4));
    m5   <= m4;
    n1_5 <= n1_4;
    n2_5 <= n2_4;

    err6 <= (t8 >= scaled5) ? (t8 - scaled5) : (scaled5 - t8);
    m6   <= m5;
    n1_6 <= n1_5;
    n2_6 <= n2_5;
  end

  assign stat.pipe_busy = v1 | v2 | v3 | v4 | v5 | v6;

  // best pair so far
  logic [ERR_W-1:0] best_err;
  logic [7:0]       best_m;
  logic [5:0]       best_n1;
  logic [1:0]       best_n2;

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      best_err <= ERR_W'({t_cl, 3'd0});
      best_m   <= DEF_M;
      best_n1  <= DEF_N1;
      best_n2  <= DEF_N2;
    end else if (v6 && (err6 < best_err)) begin
      best_err <= err6;
      best_m   <= m6;
      best_n1  <= n1_6;
      best_n2  <= n2_6;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      multiplier   <= best_m;
      divider_byte <= {best_n2, best_n1};
      clamp_code   <= clamp_r;
    end
  end

endmodule

/* rtl/pds_ctrl.sv */
// sequencer for conversion, clamp, candidate issue and result transfer
module pds_ctrl import pds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pds_stat_t stat,
  output pds_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_CLAMP    = 3'd3;
  localparam logic [2:0] ST_SEARCH   = 3'd4;
  localparam logic [2:0] ST_DRAIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    cmd         = '0;
    cmd.div_sel = sel;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = DIV_TARGET;
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          case (sel)
            DIV_TARGET: begin
              sel_next   = DIV_VMIN;
              state_next = ST_DIV_GO;
            end
            DIV_VMIN: begin
              sel_next   = DIV_VMAX;
              state_next = ST_DIV_GO;
            end
            default: begin
              state_next = ST_CLAMP;
            end
          endcase
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = stat.search_empty ? ST_DRAIN : ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && (!out_valid || out_ready)) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= DIV_TARGET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pll_divider_search.sv */
// PLL divider search: picks m, n1 and n2 for a requested clock against a 14.31818 MHz reference.
// One target at a time. The result is loaded once the search pipeline has drained and the output
// register is free, and the next target is accepted in the cycle after that. With the full ranges
// at most 252 (n1, n2) pairs are searched. The target and both VCO limits are first converted into
// q7.24 ratios, one after another through a pipelined reciprocal divider; the pairs then stream
// through a six-stage pipeline at one pair per cycle. A finished result waits in the output register
// while the next target is converted and searched; the result after it is held back until that one
// has been taken.
module pll_divider_search import pds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [KHZ_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KHZ_W-1:0] target_khz,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       multiplier,
  output logic [7:0]       divider_byte,
  output logic [1:0]       clamp_code
);

  pds_cmd_t  cmd;
  pds_stat_t stat;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .target_khz   (target_khz),
    .cmd          (cmd),
    .stat         (stat),
    .multiplier   (multiplier),
    .divider_byte (divider_byte),
    .clamp_code   (clamp_code)
  );

endmodule
